FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile all assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: src/mxt_pkg.sv
package mxt_pkg;

    localparam int KEY_BITS   = 33;
    localparam int NODE_COUNT = 4096;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int NODE_W = 2 * IDX_W;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [LVL_W-1:0]    t_lvl;

    // One trie node: the two child indices, index zero meaning no child.
    typedef struct packed {
        t_idx c1;
        t_idx c0;
    } t_node;

    // Outcome of one level of the walk.
    typedef struct packed {
        t_idx  next;
        logic  has_next;
        logic  acc_bit;
        logic  alloc;
        t_node wnode;
    } t_step;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

endpackage

FILE: src/mxt_ram.sv
module mxt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mxt_step.sv
module mxt_step (
    input  mxt_pkg::t_node i_node,
    input  logic           i_kbit,
    input  logic           i_query,
    input  logic           i_dead,
    input  mxt_pkg::t_idx  i_new_idx,
    output mxt_pkg::t_step o_step
);

    import mxt_pkg::*;

    t_idx pref_child;
    t_idx alt_child;
    t_idx own_child;

    always_comb begin
        // A query prefers the child opposite to the key bit.
        pref_child = i_kbit ? i_node.c0 : i_node.c1;
        alt_child  = i_kbit ? i_node.c1 : i_node.c0;
        own_child  = i_kbit ? i_node.c1 : i_node.c0;

        o_step          = '0;
        o_step.wnode    = i_node;

        if (i_query == REQ_QUERY) begin
            if (i_dead) begin
                o_step.has_next = 1'b0;
            end else if (pref_child != '0) begin
                o_step.next     = pref_child;
                o_step.has_next = 1'b1;
                o_step.acc_bit  = 1'b1;
            end else if (alt_child != '0) begin
                o_step.next     = alt_child;
                o_step.has_next = 1'b1;
            end else begin
                o_step.has_next = 1'b0;
            end
        end else begin
            o_step.has_next = 1'b1;
            if (own_child != '0) begin
                o_step.next = own_child;
            end else begin
                // Missing child: link a fresh node taken from the pool.
                o_step.next  = i_new_idx;
                o_step.alloc = 1'b1;
                if (i_kbit) begin
                    o_step.wnode.c1 = i_new_idx;
                end else begin
                    o_step.wnode.c0 = i_new_idx;
                end
            end
        end
    end

endmodule

FILE: src/max_xor_binary_trie.sv
// Maximum-XOR binary trie over 33-bit keys.
// Input channel: i_in_valid, o_in_stall, i_req_type, i_key. A transfer takes place
// at a rising edge with i_in_valid high and o_in_stall low. Type 0 inserts the key
// into the set, type 1 asks for the largest XOR of the key with any stored key.
// Output channel: o_out_valid, o_out_stall, o_max_xor, o_status. One result follows
// each input transfer, in order. o_max_xor is 0 for an insert; o_status is 1 when
// an insert was refused because fewer free nodes remain than a new key may need.
// Operation: an item walks the trie one level per cycle with a single read of the
// node memory each cycle; after all 33 levels the result is handed to the output
// register. A refused insert skips the walk and goes straight to that hand-over.
// One item is worked on at a time: a new item is not taken until the result of
// the last one has moved to the output register.
// Reset (synchronous, active low) is followed by an initialization pass
// that writes the path of key zero into the node memory; o_in_stall is high during it.
// The output register holds a result while i_out_stall is high; the next item may
// already be accepted, and its result waits inside until the register is free.
module max_xor_binary_trie (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  logic [mxt_pkg::KEY_BITS-1:0] i_key,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [mxt_pkg::KEY_BITS-1:0] o_max_xor,
    output logic                   o_status
);

    import mxt_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    // An insert is refused when the pool cannot take a whole new path.
    localparam t_cnt POOL_LIMIT = CNT_W'(NODE_COUNT - KEY_BITS);
    localparam t_cnt USED_RESET = CNT_W'(KEY_BITS + 1);
    localparam t_lvl LVL_TOP    = LVL_W'(KEY_BITS - 1);

    logic [1:0] r_state, n_state;
    t_lvl       r_lvl, n_lvl;
    t_lvl       r_init_idx, n_init_idx;
    t_cnt       r_used, n_used;
    t_key       r_key, n_key;
    t_key       r_acc, n_acc;
    t_idx       r_at, n_at;
    logic       r_query, n_query;
    logic       r_fresh, n_fresh;
    logic       r_dead, n_dead;
    logic       r_res_status, n_res_status;

    logic       r_out_valid, n_out_valid;
    t_key       r_out_xor, n_out_xor;
    logic       r_out_status, n_out_status;

    logic       in_xfer;
    logic       out_free;
    logic       refuse;

    logic              wr_en;
    t_idx              wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic              rd_en;
    t_idx              rd_addr;
    logic [NODE_W-1:0] rd_data;

    t_node cur_node;
    t_node init_node;
    t_step step;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign refuse   = (i_req_type == REQ_INSERT) && (r_used > POOL_LIMIT);

    // A node just taken from the pool has no children and needs no read.
    assign cur_node = r_fresh ? t_node'('0) : t_node'(rd_data);

    mxt_step u_step (
        .i_node    (cur_node),
        .i_kbit    (r_key[KEY_BITS-1]),
        .i_query   (r_query),
        .i_dead    (r_dead),
        .i_new_idx (r_used[IDX_W-1:0]),
        .o_step    (step)
    );

    // The initialization pass links node i to node i+1 through its zero child.
    always_comb begin
        init_node    = '0;
        init_node.c0 = IDX_W'(r_init_idx) + IDX_W'(1);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_at;
        wr_data = step.wnode;
        if (r_state == S_INIT) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_init_idx);
            wr_data = init_node;
        end else if (r_state == S_WALK && r_query == REQ_INSERT && step.alloc) begin
            wr_en = 1'b1;
        end
    end

    // The top node is read on the transfer; later reads follow the chosen child.
    assign rd_en   = in_xfer || (r_state == S_WALK);
    assign rd_addr = (r_state == S_WALK) ? step.next : '0;

    mxt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_lvl        = r_lvl;
        n_init_idx   = r_init_idx;
        n_used       = r_used;
        n_key        = r_key;
        n_acc        = r_acc;
        n_at         = r_at;
        n_query      = r_query;
        n_fresh      = r_fresh;
        n_dead       = r_dead;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_xor    = r_out_xor;
        n_out_status = r_out_status;

        unique case (r_state)
            S_INIT: begin
                n_init_idx = r_init_idx + LVL_W'(1);
                if (r_init_idx == LVL_TOP) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_query = i_req_type;
                    n_key   = i_key;
                    n_acc   = '0;
                    n_at    = '0;
                    n_lvl   = LVL_TOP;
                    n_fresh = 1'b0;
                    n_dead  = 1'b0;
                    if (refuse) begin
                        n_res_status = STATUS_REFUSED;
                        n_state      = S_HOLD;
                    end else begin
                        n_res_status = STATUS_DONE;
                        n_state      = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // One trie level per cycle: key bit out at the top, result bit in.
                n_key   = t_key'({r_key, 1'b0});
                n_acc   = t_key'({r_acc, step.acc_bit});
                n_at    = step.next;
                n_fresh = step.alloc;
                n_dead  = r_dead || !step.has_next;
                if (step.alloc) begin
                    n_used = r_used + CNT_W'(1);
                end
                if (r_lvl == '0) begin
                    n_state = S_HOLD;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_xor    = r_acc;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_used      <= USED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl        <= n_lvl;
        r_key        <= n_key;
        r_acc        <= n_acc;
        r_at         <= n_at;
        r_query      <= n_query;
        r_fresh      <= n_fresh;
        r_dead       <= n_dead;
        r_res_status <= n_res_status;
        r_out_xor    <= n_out_xor;
        r_out_status <= n_out_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_max_xor   = r_out_xor;
    assign o_status    = r_out_status;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_pool_overrun, r_used > CNT_W'(NODE_COUNT), "node pool count overran")
    `ASSERT_NEVER(a_query_writes, r_state == S_WALK && wr_en && r_query == REQ_QUERY, "query wrote")
    `ASSERT_PROP(a_walk_ends, r_state == S_WALK && r_lvl == '0 |=> r_state == S_HOLD, "walk overran")
    `ASSERT_PROP(a_xfer_starts, in_xfer |=> (r_state == S_WALK || r_state == S_HOLD), "bad start")

endmodule

FILE: dv/tb_max_xor_binary_trie.sv
module tb_max_xor_binary_trie;
    timeunit 1ns;
    timeprecision 1ps;

    import mxt_pkg::*;

    // Number of random requests after the directed opening.
    localparam int RANDOM_ITEMS = 830;
    // The receiver holds off once, for this many cycles, after this many results.
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 120;
    // Cycles to watch for stray results after the last expected one.
    localparam int DRAIN_CYCLES = 80;

    // One request as the driver presents it, with the idle time that follows it.
    typedef struct {
        logic        req;
        t_key        key;
        int unsigned gap;
    } t_trie_req;

    // One answer as the block should return it.
    typedef struct {
        t_key max_xor;
        logic status;
    } t_trie_answer;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_req_type  = REQ_INSERT;
    t_key i_key       = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_key o_max_xor;
    logic o_status;

    // Requests waiting to be driven, and answers waiting to come back, oldest first.
    t_trie_req    pending_reqs[$];
    t_trie_answer expected_answers[$];

    // Shadow copy of the trie: child pointers per node and the count of nodes in use.
    t_node       shadow_nodes [NODE_COUNT];
    int unsigned shadow_fill;

    int unsigned req_total;
    int unsigned reqs_taken;
    int unsigned answers_seen;
    int unsigned error_count;

    logic        req_taken;
    t_trie_req   cur_req;
    int unsigned send_idle;
    int unsigned stall_left;
    int unsigned hold_left;
    logic        hold_done;
    logic        recv_calm;

    max_xor_binary_trie dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_max_xor   (o_max_xor),
        .o_status    (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle or stall length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 75) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 45);
        return $urandom_range(46, 90);
    endfunction

    // After reset the trie holds key zero only: node 0 is the top node and
    // nodes 1..KEY_BITS form the all-zero path through child 0.
    function automatic void shadow_reset();
        for (int i = 0; i < NODE_COUNT; i++) begin
            shadow_nodes[i] = '0;
        end
        for (int i = 0; i < KEY_BITS; i++) begin
            shadow_nodes[i].c0 = t_idx'(i + 1);
        end
        shadow_fill = KEY_BITS + 1;
    endfunction

    // Insert a key, allocating each missing node on its path from the top bit
    // down. The insert is refused whole as soon as fewer free nodes remain than
    // a brand new key could need, even if this key is already in the set.
    function automatic logic shadow_insert(t_key k);
        t_idx at;
        t_idx nx;
        int   lvl;
        if (shadow_fill + KEY_BITS > NODE_COUNT) return STATUS_REFUSED;
        at = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            nx = k[lvl] ? shadow_nodes[at].c1 : shadow_nodes[at].c0;
            if (nx == '0) begin
                nx = t_idx'(shadow_fill);
                shadow_nodes[nx] = '0;
                if (k[lvl]) shadow_nodes[at].c1 = nx;
                else        shadow_nodes[at].c0 = nx;
                shadow_fill++;
            end
            at = nx;
        end
        return STATUS_DONE;
    endfunction

    // Greedy walk: at each level take the child opposite to the key bit when
    // it exists, which sets that bit of the XOR; otherwise follow the other one.
    function automatic t_key shadow_best_xor(t_key k);
        t_idx at;
        t_idx opp;
        t_idx same;
        t_key acc;
        int   lvl;
        at  = '0;
        acc = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            opp  = k[lvl] ? shadow_nodes[at].c0 : shadow_nodes[at].c1;
            same = k[lvl] ? shadow_nodes[at].c1 : shadow_nodes[at].c0;
            if (opp != '0) begin
                acc[lvl] = 1'b1;
                at = opp;
            end else if (same != '0) begin
                at = same;
            end else begin
                break;
            end
        end
        return acc;
    endfunction

    function automatic void add_req(logic req, t_key k, int unsigned gap);
        t_trie_req r;
        r.req = req;
        r.key = k;
        r.gap = gap;
        pending_reqs.push_back(r);
    endfunction

    // Input side. The driver acts on the falling edge: it keeps the payload
    // steady while the block stalls, and after each transfer it waits out the
    // idle time that came with the request before presenting the next one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (send_idle > 0) begin
                i_in_valid <= 1'b0;
                send_idle--;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= cur_req.req;
                i_key      <= cur_req.key;
                send_idle  = cur_req.gap;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Every input transfer is run through the shadow trie at the edge that
    // takes it, so the expected answers line up in transfer order.
    always @(posedge i_clk) begin
        t_trie_answer ans;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_req_type == REQ_INSERT) begin
                ans.max_xor = '0;
                ans.status  = shadow_insert(i_key);
            end else begin
                ans.max_xor = shadow_best_xor(i_key);
                ans.status  = STATUS_DONE;
            end
            expected_answers.push_back(ans);
            reqs_taken++;
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // Output side. Stalls come in random bursts, with calm stretches where
    // every result is taken at once. Once, after enough results, the receiver
    // holds off for a long time so the block backs up and stalls its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && answers_seen >= HOLD_AFTER) begin
            i_out_stall <= 1'b1;
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
            if (!recv_calm) stall_left = pick_pause();
        end
    end

    // Each result transfer is checked field by field against the oldest answer.
    always @(posedge i_clk) begin
        t_trie_answer ans;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                $error("unexpected result: max_xor %h, status %b", o_max_xor, o_status);
                error_count++;
            end else begin
                ans = expected_answers.pop_front();
                if (o_max_xor !== ans.max_xor) begin
                    $error("max_xor: expected %h, got %h", ans.max_xor, o_max_xor);
                    error_count++;
                end
                if (o_status !== ans.status) begin
                    $error("status: expected %b, got %b", ans.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_key        stored_keys[$];
        t_key        rnd;
        t_key        base;
        t_key        k;
        int unsigned sel;
        int unsigned gap;
        logic        send_calm;

        req_taken    = 1'b0;
        send_idle    = 0;
        stall_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        recv_calm    = 1'b0;
        reqs_taken   = 0;
        answers_seen = 0;
        error_count  = 0;
        send_calm    = 1'b0;
        shadow_reset();

        // Directed opening: queries against the reset set (key zero alone),
        // the extreme keys, a duplicate of the stored zero key, alternating
        // bit patterns, and single-bit keys at both ends of the word.
        add_req(REQ_QUERY,  '0, 0);
        add_req(REQ_QUERY,  '1, 0);
        add_req(REQ_QUERY,  33'h0_AAAA_AAAA, 3);
        add_req(REQ_INSERT, '0, 0);
        add_req(REQ_INSERT, '1, 0);
        add_req(REQ_QUERY,  '0, 1);
        add_req(REQ_QUERY,  '1, 0);
        add_req(REQ_INSERT, '1, 0);
        add_req(REQ_INSERT, 33'h1_0000_0000, 0);
        add_req(REQ_INSERT, 33'h0_0000_0001, 2);
        add_req(REQ_QUERY,  33'h1_0000_0000, 0);
        add_req(REQ_QUERY,  33'h0_0000_0001, 0);
        add_req(REQ_INSERT, 33'h0_AAAA_AAAA, 0);
        add_req(REQ_INSERT, 33'h1_5555_5555, 0);
        add_req(REQ_QUERY,  33'h1_5555_5555, 0);
        add_req(REQ_QUERY,  33'h0_AAAA_AAAA, 0);
        add_req(REQ_QUERY,  33'h0_FFFF_FFFF, 0);
        add_req(REQ_QUERY,  33'h1_8000_0000, 0);
        stored_keys = '{'0, '1, 33'h1_0000_0000, 33'h0_0000_0001,
                        33'h0_AAAA_AAAA, 33'h1_5555_5555};

        // Random part. Inserts mix fresh keys with near neighbors and repeats of
        // stored keys; together they exhaust the node pool partway through, so
        // later inserts, fresh and repeated alike, are refused. Queries probe
        // random keys as well as stored keys, their complements and near neighbors.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            rnd  = t_key'({$urandom(), $urandom()});
            base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
            gap = send_calm ? 0 : pick_pause();
            sel = $urandom_range(0, 19);
            if ($urandom_range(0, 99) < 45) begin
                if (sel < 10)      k = rnd;
                else if (sel < 14) k = base ^ t_key'($urandom_range(1, 4095));
                else if (sel < 18) k = base;
                else               k = t_key'($urandom_range(0, 255)) << $urandom_range(0, 25);
                stored_keys.push_back(k);
                add_req(REQ_INSERT, k, gap);
            end else begin
                if (sel < 10)      k = rnd;
                else if (sel < 14) k = base;
                else if (sel < 17) k = ~base;
                else               k = base ^ t_key'($urandom_range(1, 255));
                add_req(REQ_QUERY, k, gap);
            end
        end
        req_total = pending_reqs.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block writes the key-zero path into its node memory after reset; the driver
        // simply waits on the stall, so no extra delay is needed here.
        wait (reqs_taken == req_total);
        wait (expected_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_max_xor_binary_trie: done, clean");
        end else begin
            $display("tb_max_xor_binary_trie: done, errors");
        end
        $finish;
    end

    // Watchdog, sized well above the slowest legal run: every request with the
    // longest idle gap, the longest output stall and the full walk, plus the
    // one long hold and the initialization pass after reset.
    initial begin
        #8_000_000;
        $display("tb_max_xor_binary_trie: done, errors");
        $finish;
    end

endmodule
